// File: sv/pfas_pkg.sv
package pfas_pkg;

	// Operand and result word width
	localparam int WORD_W = 32;
	localparam int INDEX_W = 4;

	// Operation codes
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;

	// Microprogram step addresses
	localparam int STEP_W = 2;
	localparam logic [STEP_W-1:0] STEP_ACCEPT = 2'd0;
	localparam logic [STEP_W-1:0] STEP_CALC   = 2'd1;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 2'd2;
	localparam logic [STEP_W-1:0] STEP_SPARE  = 2'd3;

	// Jump conditions
	localparam logic [1:0] COND_ALWAYS = 2'd0;
	localparam logic [1:0] COND_START  = 2'd1;
	localparam logic [1:0] COND_FINAL  = 2'd2;
	localparam logic [1:0] COND_END    = 2'd3;

	// One control word of the microprogram
	typedef struct packed {
		logic              busy;
		logic              load;
		logic              calc;
		logic              emit;
		logic [1:0]        cond;
		logic [STEP_W-1:0] target;
		logic [STEP_W-1:0] fall;
	} ctrl_word_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic final_word;
		logic emit_end;
	} dp_status_t;

	// Microprogram ROM
	function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_word_t w;
		w = '0;
		case (step)
			STEP_ACCEPT: begin
				w.busy = 1'b0; w.load = 1'b1; w.cond = COND_START;
				w.target = STEP_CALC; w.fall = STEP_ACCEPT;
			end
			STEP_CALC: begin
				w.busy = 1'b1; w.calc = 1'b1; w.cond = COND_FINAL;
				w.target = STEP_EMIT; w.fall = STEP_ACCEPT;
			end
			STEP_EMIT: begin
				w.busy = 1'b1; w.emit = 1'b1; w.cond = COND_END;
				w.target = STEP_ACCEPT; w.fall = STEP_EMIT;
			end
			default: begin
				w.busy = 1'b1; w.cond = COND_ALWAYS;
				w.target = STEP_ACCEPT; w.fall = STEP_ACCEPT;
			end
		endcase
		return w;
	endfunction

endpackage

// File: sv/pfas_seq.sv
module pfas_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  pfas_pkg::dp_status_t  status,
	output pfas_pkg::ctrl_word_t  ctrl
);

	logic [pfas_pkg::STEP_W-1:0] step_q;
	logic                        take;

	// Fetch the control word of the current step
	assign ctrl = pfas_pkg::ucode_rom(step_q);

	// Evaluate the jump condition
	always_comb begin
		case (ctrl.cond)
			pfas_pkg::COND_ALWAYS: take = 1'b1;
			pfas_pkg::COND_START:  take = start;
			pfas_pkg::COND_FINAL:  take = status.final_word;
			pfas_pkg::COND_END:    take = status.emit_end;
			default:               take = 1'b1;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pfas_pkg::STEP_ACCEPT;
		end else begin
			step_q <= take ? ctrl.target : ctrl.fall;
		end
	end

endmodule

// File: sv/pfas_dp.sv
module pfas_dp #(
	parameter int MAX_WORDS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfas_pkg::ctrl_word_t          ctrl,
	input  logic                          start,
	input  logic                          req_type,
	input  logic [pfas_pkg::WORD_W-1:0]   a_word,
	input  logic [pfas_pkg::WORD_W-1:0]   b_word,
	input  logic [pfas_pkg::WORD_W-1:0]   modulus_word,
	input  logic                          last_word,
	output pfas_pkg::dp_status_t          status,
	output logic                          done,
	output logic [pfas_pkg::WORD_W-1:0]   result_word,
	output logic [pfas_pkg::INDEX_W-1:0]  word_index,
	output logic                          result_last
);

	localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam logic [IDX_W-1:0] TOP_POS = IDX_W'(MAX_WORDS - 1);

	// Latched transaction
	logic                         type_q;
	logic [pfas_pkg::WORD_W-1:0]  a_q;
	logic [pfas_pkg::WORD_W-1:0]  b_q;
	logic [pfas_pkg::WORD_W-1:0]  p_q;
	logic                         last_q;

	// Chain and control state
	logic             op_q;
	logic             c1_q;
	logic             c2_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] end_q;
	logic [IDX_W-1:0] emit_idx_q;
	logic             pick_q;

	// Result buffers
	logic [pfas_pkg::WORD_W-1:0] prim_mem [MAX_WORDS];
	logic [pfas_pkg::WORD_W-1:0] corr_mem [MAX_WORDS];
	logic [pfas_pkg::WORD_W-1:0] prim_rd_s1;
	logic [pfas_pkg::WORD_W-1:0] corr_rd_s1;
	logic                        strobe_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic                        last_s1;

	logic                        op;
	logic [pfas_pkg::WORD_W:0]   x;
	logic [pfas_pkg::WORD_W:0]   y;
	logic                        final_word;
	logic                        pick;
	logic [IDX_W+3:0]            idx_ext;

	// Word arithmetic: primary chain then correction chain
	always_comb begin
		op = (pos_q == '0) ? type_q : op_q;
		if (op == pfas_pkg::OP_ADD) begin
			x = {1'b0, a_q} + {1'b0, b_q} + {{pfas_pkg::WORD_W{1'b0}}, c1_q};
			y = {1'b0, x[pfas_pkg::WORD_W-1:0]} - {1'b0, p_q}
				- {{pfas_pkg::WORD_W{1'b0}}, c2_q};
			pick = x[pfas_pkg::WORD_W] | ~y[pfas_pkg::WORD_W];
		end else begin
			x = {1'b0, a_q} - {1'b0, b_q} - {{pfas_pkg::WORD_W{1'b0}}, c1_q};
			y = {1'b0, x[pfas_pkg::WORD_W-1:0]} + {1'b0, p_q}
				+ {{pfas_pkg::WORD_W{1'b0}}, c2_q};
			pick = x[pfas_pkg::WORD_W];
		end
		final_word = last_q | (pos_q == TOP_POS);
	end

	assign status.final_word = final_word;
	assign status.emit_end   = (emit_idx_q == end_q);

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (ctrl.load && start) begin
			type_q <= req_type;
			a_q    <= a_word;
			b_q    <= b_word;
			p_q    <= modulus_word;
			last_q <= last_word;
		end
	end

	// Hold chain bits, position and selection across the operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= pfas_pkg::OP_ADD;
			c1_q       <= 1'b0;
			c2_q       <= 1'b0;
			pos_q      <= '0;
			end_q      <= '0;
			emit_idx_q <= '0;
			pick_q     <= 1'b0;
		end else if (ctrl.calc) begin
			op_q <= op;
			if (final_word) begin
				c1_q       <= 1'b0;
				c2_q       <= 1'b0;
				pos_q      <= '0;
				end_q      <= pos_q;
				emit_idx_q <= '0;
				pick_q     <= pick;
			end else begin
				c1_q  <= x[pfas_pkg::WORD_W];
				c2_q  <= y[pfas_pkg::WORD_W];
				pos_q <= pos_q + IDX_W'(1);
			end
		end else if (ctrl.emit) begin
			emit_idx_q <= emit_idx_q + IDX_W'(1);
		end
	end

	// Buffer writes and registered reads
	always_ff @(posedge clk) begin
		if (ctrl.calc) begin
			prim_mem[pos_q] <= x[pfas_pkg::WORD_W-1:0];
			corr_mem[pos_q] <= y[pfas_pkg::WORD_W-1:0];
		end
		prim_rd_s1 <= prim_mem[emit_idx_q];
		corr_rd_s1 <= corr_mem[emit_idx_q];
		idx_s1     <= emit_idx_q;
		last_s1    <= (emit_idx_q == end_q);
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= ctrl.emit;
		end
	end

	assign idx_ext     = {4'b0000, idx_s1};
	assign done        = strobe_s1;
	assign result_word = pick_q ? corr_rd_s1 : prim_rd_s1;
	assign word_index  = idx_ext[pfas_pkg::INDEX_W-1:0];
	assign result_last = last_s1;

endmodule

// File: sv/prime_field_add_sub.sv
// Word-serial modular add / subtract over a prime field.
// Input channel: present one operand word of a, b and the modulus with
// req_type and last_word, least significant word first, and raise start.
// A transaction is taken at a clock edge where start is high and busy is low.
// req_type is sampled on the first word of an operation only; a word at
// position MAX_WORDS-1 ends the operation even without last_word.
// Each operand word is taken in the accept step, then the calculation step of
// the microprogram runs the carry/borrow chains and the buffer write.
// After the last word the block emits n result words, one per cycle, with
// done high for exactly one cycle each; the emit step reads the buffers and
// the read data and done are registered before they are shown.
// busy stays high while the result words are read out of the buffers; the
// next operation can start as the last result word is shown.
// The receiver cannot stall: each result is valid for one cycle only.
// Reset clears the sequencer, chain bits and word position; the buffers are
// not cleared, and every result word emitted is written before it is read out.
module prime_field_add_sub #(
	parameter int MAX_WORDS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [pfas_pkg::WORD_W-1:0]   a_word,
	input  logic [pfas_pkg::WORD_W-1:0]   b_word,
	input  logic [pfas_pkg::WORD_W-1:0]   modulus_word,
	input  logic                          last_word,
	output logic                          done,
	output logic [pfas_pkg::WORD_W-1:0]   result_word,
	output logic [pfas_pkg::INDEX_W-1:0]  word_index,
	output logic                          result_last
);

	pfas_pkg::ctrl_word_t ctrl;
	pfas_pkg::dp_status_t status;

	// Microprogram sequencer
	pfas_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl)
	);

	// Arithmetic and buffers
	pfas_dp #(
		.MAX_WORDS (MAX_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.start        (start),
		.req_type     (req_type),
		.a_word       (a_word),
		.b_word       (b_word),
		.modulus_word (modulus_word),
		.last_word    (last_word),
		.status       (status),
		.done         (done),
		.result_word  (result_word),
		.word_index   (word_index),
		.result_last  (result_last)
	);

	assign busy = ctrl.busy;

endmodule

// File: dv/tb_prime_field_add_sub.sv
`timescale 1ns / 100ps

module tb_prime_field_add_sub;

	import pfas_pkg::*;

	localparam int WORDS_MAX   = 16;
	localparam int WORD_TOTAL  = 360;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 3 * WORDS_MAX + 8;

	typedef struct {
		logic [WORD_W-1:0]  word;
		logic [INDEX_W-1:0] idx;
		logic               fin;
	} mod_word_t;

	// Track the modular add/subtract chains and hold the result words still owed
	class mod_result_sb;
		mod_word_t         pending_words[$];
		logic [WORD_W-1:0] sum_words[WORDS_MAX];
		logic [WORD_W-1:0] fixed_words[WORDS_MAX];
		logic              chain_x;
		logic              chain_y;
		logic              op_held;
		int                pos;
		int                errors;
		int                checked;

		function new();
			chain_x = 1'b0;
			chain_y = 1'b0;
			op_held = OP_ADD;
			pos = 0;
			errors = 0;
			checked = 0;
		endfunction

		task report(input string what);
			errors++;
			$display("[%0t] MISMATCH: %s", $realtime, what);
		endtask

		// Fold one accepted operand word into the chains; queue results on the operation's final word
		function void take_word(input logic op, input logic [WORD_W-1:0] a, b, p,
				input logic fin);
			logic [WORD_W:0] x;
			logic [WORD_W:0] y;
			logic            pick;
			mod_word_t       r;
			if (pos == 0)
				op_held = op;
			if (op_held == OP_ADD) begin
				x = {1'b0, a} + {1'b0, b} + chain_x;
				chain_x = x[WORD_W];
				y = {1'b0, x[WORD_W-1:0]} - {1'b0, p} - chain_y;
				chain_y = y[WORD_W];
			end else begin
				x = {1'b0, a} - {1'b0, b} - chain_x;
				chain_x = x[WORD_W];
				y = {1'b0, x[WORD_W-1:0]} + {1'b0, p} + chain_y;
				chain_y = y[WORD_W];
			end
			sum_words[pos] = x[WORD_W-1:0];
			fixed_words[pos] = y[WORD_W-1:0];
			if (!fin && pos < WORDS_MAX - 1) begin
				pos++;
				return;
			end
			// add: correct on carry out or no borrow; subtract: correct on borrow
			pick = (op_held == OP_ADD) ? (chain_x || !chain_y) : chain_x;
			for (int k = 0; k <= pos; k++) begin
				r.word = pick ? fixed_words[k] : sum_words[k];
				r.idx = k[INDEX_W-1:0];
				r.fin = (k == pos);
				pending_words.push_back(r);
			end
			pos = 0;
			chain_x = 1'b0;
			chain_y = 1'b0;
		endfunction

		task check_word(input logic [WORD_W-1:0] word, input logic [INDEX_W-1:0] idx,
				input logic fin);
			mod_word_t e;
			if (pending_words.size() == 0) begin
				report($sformatf("unexpected result word %h index %0d", word, idx));
				return;
			end
			e = pending_words.pop_front();
			checked++;
			if (word !== e.word)
				report($sformatf("index %0d: word %h, wanted %h", e.idx, word, e.word));
			if (idx !== e.idx)
				report($sformatf("word_index %0d, wanted %0d", idx, e.idx));
			if (fin !== e.fin)
				report($sformatf("index %0d: result_last %b, wanted %b", e.idx, fin, e.fin));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               req_type;
	logic [WORD_W-1:0]  a_word;
	logic [WORD_W-1:0]  b_word;
	logic [WORD_W-1:0]  modulus_word;
	logic               last_word;
	logic               done;
	logic [WORD_W-1:0]  result_word;
	logic [INDEX_W-1:0] word_index;
	logic               result_last;

	mod_result_sb sb;
	int           cycle_count;
	int           words_sent;
	int           ops_add;
	int           ops_sub;
	int           ops_full;

	prime_field_add_sub #(
		.MAX_WORDS(WORDS_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.a_word(a_word),
		.b_word(b_word),
		.modulus_word(modulus_word),
		.last_word(last_word),
		.done(done),
		.result_word(result_word),
		.word_index(word_index),
		.result_last(result_last)
	);

	always #4 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("prime_field_add_sub test failed");
			$finish;
		end
	end

	// Check every strobed result word
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done !== 1'b0)
			sb.check_word(result_word, word_index, result_last);
	end

	// Present one operand word and hold it until the transaction is taken
	task automatic send_word(input logic op, input logic [WORD_W-1:0] a, b, p,
			input logic fin);
		start <= 1'b1;
		req_type <= op;
		a_word <= a;
		b_word <= b;
		modulus_word <= p;
		last_word <= fin;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.take_word(op, a, b, p, fin);
		words_sent++;
	endtask

	// Drop start for an idle gap whose length is set by n, with junk on the payload
	task automatic idle_gap(input int n);
		if (n > 0) begin
			start <= 1'b0;
			req_type <= 1'($urandom_range(0, 1));
			a_word <= $urandom;
			b_word <= $urandom;
			modulus_word <= $urandom;
			last_word <= 1'($urandom_range(0, 1));
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off until every owed result word has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [WORD_W-1:0] edge_word();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return 32'h0000_0001;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Send one operation of len words; close sets last_word on the final word
	task automatic run_op(input logic op, input int len, input logic close,
			input int flavour, input logic tight);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] p;
		logic              fin;
		logic              opk;
		if (op == OP_ADD)
			ops_add++;
		else
			ops_sub++;
		if (len == WORDS_MAX && !close)
			ops_full++;
		for (int k = 0; k < len; k++) begin
			fin = (k == len - 1) ? close : 1'b0;
			a = $urandom;
			b = $urandom;
			p = $urandom;
			case (flavour)
				1: begin
					a = edge_word();
					b = edge_word();
					p = edge_word();
				end
				2: b = a;
				// a + b lands exactly on an all-ones modulus
				3: begin
					b = ~a;
					p = '1;
				end
				// keep operands below a modulus with its top bit set
				4: if (k == len - 1) begin
					p = p | 32'h8000_0000;
					a = a >> 1;
					b = b >> 1;
				end
				default: ;
			endcase
			// req_type past the first word must be ignored
			opk = (k == 0) ? op : logic'($urandom_range(0, 1));
			send_word(opk, a, b, p, fin);
			if (k < len - 1 && !tight)
				idle_gap(pick_gap());
		end
	endtask

	initial begin
		logic op;
		int   len;
		int   r;
		logic close;
		logic tight;

		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= OP_ADD;
		a_word <= '0;
		b_word <= '0;
		modulus_word <= '0;
		last_word <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-word extremes of both operations
		send_word(OP_ADD, 32'h0, 32'h0, 32'h7, 1'b1);
		send_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b1);
		idle_gap(2);
		send_word(OP_ADD, 32'h5, 32'h6, 32'hB, 1'b1);
		send_word(OP_SUB, 32'h2, 32'h9, 32'hB, 1'b1);
		send_word(OP_SUB, 32'h9, 32'h9, 32'hB, 1'b1);
		idle_gap(1);
		send_word(OP_SUB, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		ops_add += 3;
		ops_sub += 3;
		// Two words with a carry across; the second req_type must be ignored
		send_word(OP_ADD, 32'hFFFF_FFFF, 32'h1, 32'h3, 1'b0);
		send_word(OP_SUB, 32'h5, 32'h6, 32'h20, 1'b1);
		ops_add++;
		// Full buffer with no last word: the top word closes the operation
		run_op(OP_SUB, WORDS_MAX, 1'b0, 0, 1'b1);
		drain();

		// Random operations, mostly short
		while (words_sent < WORD_TOTAL) begin
			op = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (r < 80)
				len = $urandom_range(1, 4);
			else if (r < 94)
				len = $urandom_range(5, WORDS_MAX - 1);
			else
				len = WORDS_MAX;
			close = (len < WORDS_MAX) ? 1'b1 : logic'($urandom_range(0, 1));
			tight = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				drain();
			else if (!tight)
				idle_gap(pick_gap());
			run_op(op, len, close, $urandom_range(0, 4), tight);
		end

		drain();
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d operand words in %0d adds and %0d subtracts (%0d full-buffer).",
			words_sent, ops_add, ops_sub, ops_full);
		$display("Checked %0d result words, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("prime_field_add_sub test passed");
		else
			$display("prime_field_add_sub test failed");
		$finish;
	end

endmodule
